[hw/rtl/pli_pkg.sv]
// Package for the positional list unit: sizes, command and status codes, cell control.
`default_nettype none
package pli_pkg;

  localparam int CAPACITY  = 64;
  localparam int CMD_W     = 2;
  localparam int POS_W     = 6;
  localparam int VAL_W     = 32;
  localparam int STAT_W    = 2;
  localparam int CNT_OUT_W = 7;
  localparam int CNT_W     = $clog2(CAPACITY + 1);

  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_DELETE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ   = 2'd2;

  localparam logic [STAT_W-1:0] ST_DONE  = 2'd0;
  localparam logic [STAT_W-1:0] ST_RANGE = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd3;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_INS,
    OP_DEL
  } op_t;

  typedef struct packed {
    op_t                     op;
    logic [CNT_W-1:0]        pos;
    logic [CNT_W-1:0]        count;
    logic signed [VAL_W-1:0] value;
  } cell_ctl_t;

endpackage
`default_nettype wire

[hw/rtl/pli_if.sv]
// Valid/ready channel interfaces for list commands and list results.
`default_nettype none
interface pli_in_if;
  logic                               valid;
  logic                               ready;
  logic [pli_pkg::CMD_W-1:0]          cmd;
  logic [pli_pkg::POS_W-1:0]          position;
  logic signed [pli_pkg::VAL_W-1:0]   value;

  modport source (output valid, output cmd, output position, output value, input ready);
  modport sink   (input valid, input cmd, input position, input value, output ready);
endinterface

interface pli_out_if;
  logic                               valid;
  logic                               ready;
  logic [pli_pkg::STAT_W-1:0]         status;
  logic [pli_pkg::CNT_OUT_W-1:0]      count;
  logic signed [pli_pkg::VAL_W-1:0]   read_value;

  modport source (output valid, output status, output count, output read_value, input ready);
  modport sink   (input valid, input status, input count, input read_value, output ready);
endinterface
`default_nettype wire

[hw/rtl/pli_cell.sv]
// One list cell: holds an entry and loads, shifts up or shifts down as told.
`default_nettype none
module pli_cell (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire pli_pkg::cell_ctl_t               ctl,
  input  wire logic [pli_pkg::CNT_W-1:0]        idx,
  input  wire logic signed [pli_pkg::VAL_W-1:0] left_data,
  input  wire logic signed [pli_pkg::VAL_W-1:0] right_data,
  output logic signed [pli_pkg::VAL_W-1:0]      data,
  output logic signed [pli_pkg::VAL_W-1:0]      sel_data
);
  import pli_pkg::*;

  logic signed [VAL_W-1:0] data_r;
  logic signed [VAL_W-1:0] data_nxt;

  always_comb begin
    data_nxt = data_r;
    case (ctl.op)
      OP_INS: begin
        if (idx == ctl.pos) begin
          data_nxt = ctl.value;
        end else if (ctl.pos < ctl.count && idx > ctl.pos && idx <= ctl.count) begin
          data_nxt = left_data;
        end
      end
      OP_DEL: begin
        if (idx >= ctl.pos && idx < ctl.count) begin
          data_nxt = right_data;
        end
      end
      default: begin
        data_nxt = data_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      data_r <= '0;
    end else begin
      data_r <= data_nxt;
    end
  end

  assign data     = data_r;
  assign sel_data = (idx == ctl.pos) ? data_r : '0;

endmodule
`default_nettype wire

[hw/rtl/pli_chain.sv]
// Row of list cells with neighbor links and the read-out bus.
`default_nettype none
module pli_chain (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire pli_pkg::cell_ctl_t               ctl,
  output logic signed [pli_pkg::VAL_W-1:0]      rd_data
);
  import pli_pkg::*;

  logic signed [VAL_W-1:0] entry [CAPACITY];
  logic signed [VAL_W-1:0] sel   [CAPACITY];

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [VAL_W-1:0] left_d;
    logic signed [VAL_W-1:0] right_d;

    if (i == 0) begin : g_first
      assign left_d = '0;
    end else begin : g_mid_l
      assign left_d = entry[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_d = '0;
    end else begin : g_mid_r
      assign right_d = entry[i+1];
    end

    pli_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctl        (ctl),
      .idx        (CNT_W'(i)),
      .left_data  (left_d),
      .right_data (right_d),
      .data       (entry[i]),
      .sel_data   (sel[i])
    );
  end

  always_comb begin
    rd_data = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      rd_data = rd_data | sel[i];
    end
  end

endmodule
`default_nettype wire

[hw/rtl/positional_list_insert_delete_unit.sv]
// Positional list unit: ordered list of signed words with insert, delete and read.
//
// Usage:
//   in_ch carries one command item (cmd, position, value); out_ch returns exactly one
//   result item (status, count, read_value) for each accepted command, in order.
//   Commands: insert shifts later entries up, delete shifts them down and returns the
//   removed word, read returns the entry at the position. A full list rejects an
//   insert inside the list; a missing element gives a status and a zero word.
//   Latency: the result is valid on the cycle after the command is accepted.
//   Throughput: one command per cycle while out_ch.ready is high; every cell of the row
//   updates in the accept cycle, and the result register is the only stage.
//   Stall: while a result waits in the output register and out_ch.ready is low,
//   in_ch.ready is low and the list holds.
//   Reset: rst_n (synchronous, active low) clears every entry to zero, the count
//   to zero and the output register to empty.
`default_nettype none
module positional_list_insert_delete_unit (
  input  wire logic  clk,
  input  wire logic  rst_n,
  pli_in_if.sink     in_ch,
  pli_out_if.source  out_ch
);
  import pli_pkg::*;

  logic                    out_valid_r;
  logic [STAT_W-1:0]       status_r;
  logic [STAT_W-1:0]       status_nxt;
  logic [CNT_W-1:0]        cnt_r;
  logic [CNT_W-1:0]        cnt_nxt;
  logic signed [VAL_W-1:0] rd_r;
  logic signed [VAL_W-1:0] rd_nxt;
  logic signed [VAL_W-1:0] chain_rd;
  logic [CNT_W-1:0]        pos_c;
  logic                    in_range;
  logic                    accept;
  op_t                     op;
  cell_ctl_t               ctl;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;
  assign pos_c       = CNT_W'(in_ch.position);
  assign in_range    = 32'(in_ch.position) < 32'(CAPACITY);

  always_comb begin
    status_nxt = ST_DONE;
    cnt_nxt    = cnt_r;
    rd_nxt     = '0;
    op         = OP_NONE;
    case (in_ch.cmd)
      CMD_INSERT: begin
        if (!in_range) begin
          status_nxt = ST_RANGE;
        end else if (pos_c < cnt_r) begin
          if (32'(cnt_r) >= 32'(CAPACITY)) begin
            status_nxt = ST_FULL;
          end else begin
            op      = OP_INS;
            cnt_nxt = cnt_r + CNT_W'(1);
          end
        end else begin
          op      = OP_INS;
          cnt_nxt = pos_c + CNT_W'(1);
        end
      end
      CMD_DELETE: begin
        if (!in_range) begin
          status_nxt = ST_RANGE;
        end else if (pos_c >= cnt_r) begin
          status_nxt = ST_EMPTY;
        end else begin
          op      = OP_DEL;
          rd_nxt  = chain_rd;
          cnt_nxt = cnt_r - CNT_W'(1);
        end
      end
      CMD_READ: begin
        if (!in_range) begin
          status_nxt = ST_RANGE;
        end else if (pos_c >= cnt_r) begin
          status_nxt = ST_EMPTY;
        end else begin
          rd_nxt = chain_rd;
        end
      end
      default: begin
        status_nxt = ST_DONE;
      end
    endcase
  end

  always_comb begin
    ctl.op    = accept ? op : OP_NONE;
    ctl.pos   = pos_c;
    ctl.count = cnt_r;
    ctl.value = in_ch.value;
  end

  pli_chain u_chain (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (ctl),
    .rd_data (chain_rd)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
    end else begin
      if (accept) begin
        out_valid_r <= 1'b1;
        cnt_r       <= cnt_nxt;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status_r <= status_nxt;
      rd_r     <= rd_nxt;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.status     = status_r;
  assign out_ch.count      = CNT_OUT_W'(cnt_r);
  assign out_ch.read_value = rd_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(cnt_r) <= 32'(CAPACITY))
    else $error("list count beyond capacity");

  a_delete_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
    accept && op == OP_DEL |=> cnt_r == $past(cnt_r) - CNT_W'(1))
    else $error("delete did not shrink the count");

  a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && status_r == ST_FULL |-> 32'(cnt_r) == 32'(CAPACITY))
    else $error("full status with a list that is not full");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ch.ready |=> $stable(cnt_r) && $stable(rd_r))
    else $error("list changed while a result was stalled");

endmodule
`default_nettype wire

[test/tb_positional_list_insert_delete_unit.sv]
// Testbench for the positional list unit: directed table plus random commands, checked by a predictor.
`timescale 1ns / 1ps
module tb_positional_list_insert_delete_unit;
  import pli_pkg::*;

  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int N_DIRECTED   = 22;
  localparam int RANDOM_ITEMS = 1500;
  localparam int HOLD_AFTER   = 500;
  localparam int HOLD_CYCLES  = 300;
  localparam int CYCLE_LIMIT  = 500000;

  typedef struct packed {
    logic [STAT_W-1:0]       status;
    logic [CNT_OUT_W-1:0]    count;
    logic signed [VAL_W-1:0] read_value;
  } list_result_t;

  typedef struct packed {
    logic [CMD_W-1:0]        cmd;
    logic [POS_W-1:0]        position;
    logic signed [VAL_W-1:0] value;
    logic                    typed;
    list_result_t            result;
  } cmd_row_t;

  logic clk = 1'b0;
  logic rst_n;
  logic holding = 1'b0;
  logic no_idle = 1'b0;
  int   accepted_items = 0;
  int   mismatch_count = 0;
  int   cycle_count = 0;

  logic signed [VAL_W-1:0] list_words [CAPACITY];
  int                      list_count = 0;
  list_result_t            pending_results [$];
  cmd_row_t                directed_rows [N_DIRECTED];

  pli_in_if  in_ch ();
  pli_out_if out_ch ();

  positional_list_insert_delete_unit dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic list_result_t apply_list_cmd(input logic [CMD_W-1:0] c,
                                                  input logic [POS_W-1:0] p,
                                                  input logic signed [VAL_W-1:0] v);
    list_result_t r;
    int pos;
    r = '0;
    r.status = ST_DONE;
    pos = int'(p);
    if (c != CMD_UNUSED && pos >= CAPACITY) begin
      r.status = ST_RANGE;
    end else begin
      case (c)
        CMD_INSERT: begin
          if (pos < list_count) begin
            if (list_count >= CAPACITY) begin
              r.status = ST_FULL;
            end else begin
              for (int i = list_count; i > pos; i--) list_words[i] = list_words[i-1];
              list_words[pos] = v;
              list_count++;
            end
          end else begin
            list_words[pos] = v;
            list_count = pos + 1;
          end
        end
        CMD_DELETE, CMD_READ: begin
          if (pos >= list_count) begin
            r.status = ST_EMPTY;
          end else begin
            r.read_value = list_words[pos];
            if (c == CMD_DELETE) begin
              for (int i = pos; i + 1 < list_count; i++) list_words[i] = list_words[i+1];
              if (list_count < CAPACITY) list_words[list_count-1] = list_words[list_count];
              else list_words[list_count-1] = '0;
              list_count--;
            end
          end
        end
        default: begin
        end
      endcase
    end
    r.count = CNT_OUT_W'(list_count);
    return r;
  endfunction

  function automatic int pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (mismatch_count < 40)
      $display("%0t mismatch %s: got %h expected %h", $time, what, got, want);
    mismatch_count++;
  endtask

  // hold the item until accepted, then predict its result
  task automatic offer_cmd(input logic [CMD_W-1:0] c, input logic [POS_W-1:0] p,
                           input logic signed [VAL_W-1:0] v, input logic typed,
                           input list_result_t typed_result);
    int gap;
    list_result_t predicted;
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.cmd      <= c;
    in_ch.position <= p;
    in_ch.value    <= v;
    do @(posedge clk); while (!in_ch.ready);
    predicted = apply_list_cmd(c, p, v);
    pending_results.push_back(typed ? typed_result : predicted);
    accepted_items++;
  endtask

  function automatic logic [POS_W-1:0] pick_position();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 75 && list_count > 0) return POS_W'($urandom_range(0, list_count - 1));
    if (r < 85) return POS_W'((list_count > CAPACITY - 1) ? CAPACITY - 1 : list_count);
    if (r < 93) return POS_W'($urandom_range(0, CAPACITY - 1));
    if (r < 97) return POS_W'(CAPACITY - 1);
    return '0;
  endfunction

  function automatic logic signed [VAL_W-1:0] pick_value();
    case ($urandom_range(0, 39))
      0: return 32'sh7FFF_FFFF;
      1: return 32'sh8000_0000;
      2: return '0;
      3: return '1;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [CMD_W-1:0] pick_cmd(input int mode);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 3) return CMD_UNUSED;
    case (mode)
      0: return (r < 70) ? CMD_INSERT : (r < 88) ? CMD_DELETE : CMD_READ;
      1: return (r < 22) ? CMD_INSERT : (r < 88) ? CMD_DELETE : CMD_READ;
      default: return (r < 37) ? CMD_INSERT : (r < 70) ? CMD_DELETE : CMD_READ;
    endcase
  endfunction

  initial begin
    int mode;
    logic [CMD_W-1:0] c;
    directed_rows = '{
      '{CMD_READ,   6'd0,  32'sh0,         1'b1, '{ST_EMPTY, 7'd0,  32'sh0}},
      '{CMD_DELETE, 6'd0,  32'sh0,         1'b1, '{ST_EMPTY, 7'd0,  32'sh0}},
      '{CMD_UNUSED, 6'd5,  32'shFFFF_FFFF, 1'b1, '{ST_DONE,  7'd0,  32'sh0}},
      '{CMD_INSERT, 6'd63, 32'sh7FFF_FFFF, 1'b1, '{ST_DONE,  7'd64, 32'sh0}},
      '{CMD_READ,   6'd10, 32'sh0,         1'b1, '{ST_DONE,  7'd64, 32'sh0}},
      '{CMD_READ,   6'd63, 32'sh0,         1'b1, '{ST_DONE,  7'd64, 32'sh7FFF_FFFF}},
      '{CMD_INSERT, 6'd0,  32'sh8000_0000, 1'b1, '{ST_FULL,  7'd64, 32'sh0}},
      '{CMD_INSERT, 6'd63, 32'shFFFF_FFFF, 1'b1, '{ST_FULL,  7'd64, 32'sh0}},
      '{CMD_DELETE, 6'd63, 32'sh0,         1'b1, '{ST_DONE,  7'd63, 32'sh7FFF_FFFF}},
      '{CMD_INSERT, 6'd63, 32'sh8000_0000, 1'b1, '{ST_DONE,  7'd64, 32'sh0}},
      '{CMD_DELETE, 6'd0,  32'sh0,         1'b1, '{ST_DONE,  7'd63, 32'sh0}},
      '{CMD_READ,   6'd62, 32'sh0,         1'b1, '{ST_DONE,  7'd63, 32'sh8000_0000}},
      '{CMD_READ,   6'd63, 32'sh0,         1'b1, '{ST_EMPTY, 7'd63, 32'sh0}},
      '{CMD_INSERT, 6'd0,  32'sh1234_5678, 1'b0, '0},
      '{CMD_UNUSED, 6'd0,  32'sh0,         1'b1, '{ST_DONE,  7'd64, 32'sh0}},
      '{CMD_DELETE, 6'd62, 32'sh0,         1'b0, '0},
      '{CMD_DELETE, 6'd10, 32'sh0,         1'b0, '0},
      '{CMD_READ,   6'd61, 32'sh0,         1'b0, '0},
      '{CMD_INSERT, 6'd62, 32'shFFFF_FFFF, 1'b0, '0},
      '{CMD_INSERT, 6'd30, 32'sh0,         1'b0, '0},
      '{CMD_READ,   6'd63, 32'sh0,         1'b0, '0},
      '{CMD_DELETE, 6'd0,  32'sh0,         1'b0, '0}
    };
    for (int i = 0; i < CAPACITY; i++) list_words[i] = '0;
    rst_n          <= 1'b0;
    in_ch.valid    <= 1'b0;
    in_ch.cmd      <= '0;
    in_ch.position <= '0;
    in_ch.value    <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i])
      offer_cmd(directed_rows[i].cmd, directed_rows[i].position, directed_rows[i].value,
                directed_rows[i].typed, directed_rows[i].result);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 100 == 0) begin
        mode = $urandom_range(0, 2);
        no_idle = ($urandom_range(0, 3) == 0);
      end
      c = pick_cmd(mode);
      offer_cmd(c, pick_position(), pick_value(), 1'b0, '0);
    end
    in_ch.valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0)
      $display("** positional_list_insert_delete_unit: PASSED **");
    else
      $display("** positional_list_insert_delete_unit: FAILED **");
    $finish;
  end

  initial begin
    int stall_left;
    int free_left;
    stall_left = 0;
    free_left = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (holding) begin
        out_ch.ready <= 1'b0;
      end else if (stall_left > 0) begin
        out_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        out_ch.ready <= 1'b1;
        if (free_left > 0) free_left--;
        else if ($urandom_range(0, 9) < 3) stall_left = pick_gap();
        else if ($urandom_range(0, 99) == 0) free_left = $urandom_range(50, 200);
      end
    end
  end

  // hold off the result side long enough for the input to stall
  initial begin
    wait (accepted_items >= HOLD_AFTER);
    @(posedge clk);
    holding <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    holding <= 1'b0;
  end

  always @(posedge clk) begin
    list_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with nothing pending", out_ch.read_value, '0);
      end else begin
        want = pending_results.pop_front();
        if (out_ch.status !== want.status)
          report_mismatch("status", 32'(out_ch.status), 32'(want.status));
        if (out_ch.count !== want.count)
          report_mismatch("count", 32'(out_ch.count), 32'(want.count));
        if (out_ch.read_value !== want.read_value)
          report_mismatch("read_value", out_ch.read_value, want.read_value);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("** positional_list_insert_delete_unit: FAILED **");
      $finish;
    end
  end

endmodule
